FILE: rtl/hsps_pkg.sv
// ----------------------------------------------------------------------------
// HEVC SPS header parser package
// Shared request types, syntax step codes, state machine types and the table
// of fixed field widths used by the parser and its rate reduction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hsps_pkg;

  localparam int unsigned MAX_SUBLAYERS = 8;
  localparam logic [17:0] CROP_MAX      = 18'h3FFFF;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hsps_in_t;

  typedef struct packed {
    logic [3:0]  param_set_id;
    logic [15:0] pic_width;
    logic [15:0] pic_height;
    logic [4:0]  luma_depth;
    logic [4:0]  profile_code;
    logic [7:0]  level_code;
    logic [6:0]  rps_count;
    logic [31:0] rate_num;
    logic [31:0] rate_den;
    logic [1:0]  status;
  } hsps_out_t;

  typedef enum logic [5:0] {
    ST_HEAD, ST_PTL_A, ST_PTL_B, ST_LEVEL, ST_SUBFLAGS, ST_SUBPTL, ST_SUBPTL_SKIP,
    ST_ID, ST_CHROMA, ST_SEP, ST_WIDTH, ST_HEIGHT, ST_CONF, ST_CONF_OFS,
    ST_LUMA, ST_CDEPTH, ST_POC, ST_ORDER, ST_ORDER_UE, ST_SIZES,
    ST_SL_EN, ST_SL_PRESENT, ST_SL_PRED, ST_SL_DELTA, ST_SL_COEF,
    ST_AMP, ST_PCM, ST_PCM_BITS, ST_PCM_UE, ST_PCM_LF,
    ST_NRPS, ST_RPS_BEGIN, ST_RPS_PRED, ST_RPS_SIGN, ST_RPS_ABS, ST_RPS_USED,
    ST_RPS_USEDELTA, ST_RPS_NEG, ST_RPS_POS, ST_RPS_DELTA, ST_RPS_USEDFLAG,
    ST_LT, ST_LT_NUM, ST_LT_ITEM, ST_TMVP, ST_VUI, ST_SAR, ST_SAR_IDC,
    ST_SAR_VAL, ST_OVERSCAN, ST_OVS_APP, ST_VST, ST_VST_BITS, ST_COLOUR_BITS,
    ST_CLOC, ST_CLOC_UE, ST_THREE, ST_DDW, ST_DDW_UE, ST_TIMING, ST_T_UNITS,
    ST_T_SCALE, ST_DONE
  } step_e;

  typedef enum logic [2:0] {
    RM_NONE, RM_FIXED, RM_GPRE, RM_GSUF, RM_ISSUE
  } rmode_e;

  typedef enum logic [1:0] {
    C_WAIT, C_BITS, C_RATE
  } ctl_e;

  typedef enum logic [2:0] {
    R_DONE, R_TWOS, R_AODD, R_LOOP, R_DIV_N, R_DIV_D
  } rate_e;

  function automatic logic [6:0] fixed_width(step_e s);
    logic [6:0] w;
    case (s)
      ST_HEAD, ST_PTL_A, ST_LEVEL, ST_PCM_BITS, ST_SAR_IDC: w = 7'd8;
      ST_PTL_B:                                            w = 7'd80;
      ST_AMP, ST_TMVP:                                     w = 7'd2;
      ST_SAR_VAL, ST_T_UNITS, ST_T_SCALE:                  w = 7'd32;
      ST_VST_BITS:                                         w = 7'd5;
      ST_COLOUR_BITS:                                      w = 7'd24;
      ST_THREE:                                            w = 7'd3;
      ST_SEP, ST_CONF, ST_ORDER, ST_SL_EN, ST_SL_PRESENT, ST_SL_PRED, ST_PCM,
      ST_PCM_LF, ST_RPS_PRED, ST_RPS_SIGN, ST_RPS_USED, ST_RPS_USEDELTA,
      ST_RPS_USEDFLAG, ST_LT, ST_VUI, ST_SAR, ST_OVERSCAN, ST_OVS_APP, ST_VST,
      ST_CLOC, ST_DDW, ST_TIMING:                          w = 7'd1;
      default:                                             w = 7'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hsps_rate_unit.sv
// ----------------------------------------------------------------------------
// HEVC SPS frame rate reduction unit
// Finds the gcd of time scale and units per tick with a binary gcd loop, then
// divides both by it through one shared restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hsps_rate_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] scale_i,
  input  logic [31:0] units_i,
  output logic        done_o,
  output logic [31:0] num_o,
  output logic [31:0] den_o
);
  import hsps_pkg::*;

  rate_e       st_q, st_d;
  logic [31:0] a_q, a_d, b_q, b_d;
  logic [4:0]  k_q, k_d;
  logic [31:0] scale_q, scale_d, units_q, units_d;
  logic [31:0] g_q, g_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] num_q, num_d, den_q, den_d;

  logic [32:0] div_shift, div_diff;
  logic        div_bit;
  logic [31:0] quo_next;

  assign div_shift = {rem_q, quo_q[31]};
  assign div_diff  = div_shift - {1'b0, g_q};
  assign div_bit   = !div_diff[32];
  assign quo_next  = {quo_q[30:0], div_bit};

  always_comb begin
    st_d = st_q;
    case (st_q)
      R_DONE: begin
        if (start_i) begin
          if (scale_i == '0 && units_i == '0) begin
            st_d = R_DONE;
          end else if (scale_i == '0 || units_i == '0) begin
            st_d = R_DIV_N;
          end else begin
            st_d = R_TWOS;
          end
        end
      end
      R_TWOS: begin
        if (a_q[0] || b_q[0]) begin
          st_d = R_AODD;
        end
      end
      R_AODD: begin
        if (a_q[0]) begin
          st_d = R_LOOP;
        end
      end
      R_LOOP: begin
        if (b_q == '0) begin
          st_d = R_DIV_N;
        end
      end
      R_DIV_N: begin
        if (cnt_q == '0) begin
          st_d = R_DIV_D;
        end
      end
      R_DIV_D: begin
        if (cnt_q == '0) begin
          st_d = R_DONE;
        end
      end
      default: st_d = R_DONE;
    endcase
  end

  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    scale_d = scale_q;
    units_d = units_q;
    g_d     = g_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    den_d   = den_q;
    case (st_q)
      R_DONE: begin
        if (start_i) begin
          scale_d = scale_i;
          units_d = units_i;
          a_d     = scale_i;
          b_d     = units_i;
          k_d     = '0;
          num_d   = '0;
          den_d   = '0;
          g_d     = (scale_i == '0) ? units_i : scale_i;
          quo_d   = scale_i;
          rem_d   = '0;
          cnt_d   = 5'd31;
        end
      end
      R_TWOS: begin
        if (!a_q[0] && !b_q[0]) begin
          a_d = {1'b0, a_q[31:1]};
          b_d = {1'b0, b_q[31:1]};
          k_d = k_q + 5'd1;
        end
      end
      R_AODD: begin
        if (!a_q[0]) begin
          a_d = {1'b0, a_q[31:1]};
        end
      end
      R_LOOP: begin
        if (b_q == '0) begin
          g_d   = a_q << k_q;
          quo_d = scale_q;
          rem_d = '0;
          cnt_d = 5'd31;
        end else if (!b_q[0]) begin
          b_d = {1'b0, b_q[31:1]};
        end else if (a_q > b_q) begin
          a_d = b_q;
          b_d = a_q;
        end else begin
          b_d = b_q - a_q;
        end
      end
      R_DIV_N, R_DIV_D: begin
        rem_d = div_bit ? div_diff[31:0] : div_shift[31:0];
        quo_d = quo_next;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          if (st_q == R_DIV_N) begin
            num_d = quo_next;
            quo_d = units_q;
            rem_d = '0;
            cnt_d = 5'd31;
          end else begin
            den_d = quo_next;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= R_DONE;
      num_q <= '0;
      den_q <= '0;
      cnt_q <= '0;
      k_q   <= '0;
    end else begin
      st_q  <= st_d;
      num_q <= num_d;
      den_q <= den_d;
      cnt_q <= cnt_d;
      k_q   <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    scale_q <= scale_d;
    units_q <= units_d;
    g_q     <= g_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
  end

  assign done_o = (st_q == R_DONE);
  assign num_o  = num_q;
  assign den_o  = den_q;

endmodule

`default_nettype wire

FILE: rtl/hevc_sps_header_parser.sv
// ----------------------------------------------------------------------------
// HEVC SPS header parser
// Walks the syntax of one sequence parameter set bit by bit and reports the
// id, cropped picture size, depth, profile, level, set count and frame rate.
// ----------------------------------------------------------------------------
// Each payload byte is shifted through a serial syntax walker one bit per
// cycle, with a pause for each field that starts in it (the walker then
// chooses the next field and may also step over sub-layer entries). On the
// last byte the frame rate goes through a shared reduction unit: a binary
// gcd followed by two divisions, after which the result request is
// presented. The next SPS may start while a result waits.
`default_nettype none

module hevc_sps_header_parser #(
  parameter int unsigned MAX_RPS_SETS = 64,
  parameter int unsigned MAX_RPS_PICS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hsps_pkg::hsps_in_t   in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hsps_pkg::hsps_out_t  out_req_o
);
  import hsps_pkg::*;

  localparam int unsigned SETW = $clog2(MAX_RPS_SETS + 1);
  localparam int unsigned PICW = $clog2(MAX_RPS_PICS + 2);
  localparam int unsigned LCW  = (SETW > 3) ? SETW : 3;
  localparam int unsigned ICW  = (PICW > 6) ? PICW : 6;

  ctl_e              ctl_q, ctl_d;
  logic [7:0]        byte_q, byte_d;
  logic              last_q, last_d;
  logic [3:0]        bit_cnt_q, bit_cnt_d;

  step_e             step_q, step_d;
  rmode_e            mode_q, mode_d;
  logic [6:0]        left_q, left_d;
  logic [5:0]        gz_q, gz_d;
  logic [31:0]       fv_q, fv_d;
  logic [LCW-1:0]    loop_q, loop_d;
  logic [ICW-1:0]    inner_q, inner_d;
  logic [13:0]       subflags_q, subflags_d;
  logic [3:0]        subtot_q, subtot_d;
  logic [1:0]        chroma_q, chroma_d;
  logic [15:0]       width_q, width_d, height_q, height_d;
  logic [17:0]       crop_w_q, crop_w_d, crop_h_q, crop_h_d;
  logic [4:0]        poc_q, poc_d;
  logic [PICW-1:0]   prev_q, prev_d, cur_q, cur_d;
  logic [3:0]        id_q, id_d;
  logic [4:0]        depth_q, depth_d, profile_q, profile_d;
  logic [7:0]        level_q, level_d;
  logic [31:0]       scale_q, scale_d, units_q, units_d;
  logic              ovf_q, ovf_d;
  logic [SETW-1:0]   set_q, set_d;
  logic [6:0]        aux_q, aux_d;

  hsps_out_t         pend_q, pend_d;
  hsps_out_t         out_q;
  logic              out_valid_q;

  logic              in_take, finish, out_load, rate_start;
  logic              rate_done;
  logic [31:0]       rate_num, rate_den, rate_a, rate_b;
  logic [1:0]        status;

  logic              deliver, do_fail, rps_pic;
  logic [31:0]       dval;
  logic              bit_in;
  logic [31:0]       fv_shift, gsuf_val;
  logic              crop_side, crop_mult2;
  logic [17:0]       crop_base, crop_new;
  logic [33:0]       crop_add;
  logic [4:0]        fb5;
  logic [3:0]        sub_fb;
  logic [6:0]        sub_n;
  logic [4:0]        sub_sh;
  logic [ICW-1:0]    sl_inner;
  logic              sl_wrap;
  logic [LCW-1:0]    sl_loop;
  logic [PICW-1:0]   cur_inc, rps_c;
  logic [3:0]        head_tot;
  logic [6:0]        pos_sum;

  assign bit_in     = byte_q[7];
  assign fv_shift   = {fv_q[30:0], bit_in};
  assign gsuf_val   = ((32'd1 << gz_q) - 32'd1) + fv_shift;
  assign crop_side  = (inner_q >= ICW'(2));
  assign crop_mult2 = crop_side ? (chroma_q == 2'd1) : (chroma_q == 2'd1 || chroma_q == 2'd2);
  assign crop_base  = crop_side ? crop_h_q : crop_w_q;
  assign crop_add   = {16'd0, crop_base} + (crop_mult2 ? {1'b0, dval, 1'b0} : {2'b00, dval});
  assign crop_new   = (crop_add > 34'(CROP_MAX)) ? CROP_MAX : crop_add[17:0];
  assign fb5        = {subtot_q - 4'd1, 1'b0} - 5'd1 - {1'b0, loop_q[2:0], 1'b0};
  assign sub_fb     = fb5[3:0];
  assign sub_n      = (subflags_q[sub_fb] ? 7'd88 : 7'd0) +
                      (subflags_q[sub_fb - 4'd1] ? 7'd8 : 7'd0);
  assign sub_sh     = {4'd9 - subtot_q, 1'b0};
  assign sl_inner   = inner_q + ((loop_q == LCW'(3)) ? ICW'(3) : ICW'(1));
  assign sl_wrap    = (sl_inner >= ICW'(6));
  assign sl_loop    = loop_q + (sl_wrap ? LCW'(1) : LCW'(0));
  assign cur_inc    = cur_q + PICW'(1);
  assign head_tot   = {1'b0, dval[3:1]} + 4'd1;
  assign pos_sum    = aux_q + dval[6:0];
  assign rps_c      = (step_q == ST_RPS_USEDELTA && dval == '0) ? cur_q : cur_inc;
  assign rps_pic    = (step_q == ST_RPS_USEDELTA) || (step_q == ST_RPS_USED && dval != '0);

  assign status = ovf_q ? STAT_RANGE : ((step_q != ST_DONE) ? STAT_SHORT : STAT_OK);
  assign rate_a = (status == STAT_OK) ? scale_q : '0;
  assign rate_b = (status == STAT_OK) ? units_q : '0;

  // Sequencer next state.
  always_comb begin
    ctl_d = ctl_q;
    case (ctl_q)
      C_WAIT: begin
        if (in_valid_i) begin
          ctl_d = C_BITS;
        end
      end
      C_BITS: begin
        if (mode_q != RM_ISSUE && bit_cnt_q == '0) begin
          ctl_d = last_q ? C_RATE : C_WAIT;
        end
      end
      C_RATE: begin
        if (rate_done && (!out_valid_q || !out_stall_i)) begin
          ctl_d = C_WAIT;
        end
      end
      default: ctl_d = C_WAIT;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = (ctl_q != C_WAIT);
    in_take    = (ctl_q == C_WAIT) && in_valid_i;
    finish     = (ctl_q == C_BITS) && (mode_q != RM_ISSUE) && (bit_cnt_q == '0);
    rate_start = finish && last_q;
    out_load   = (ctl_q == C_RATE) && rate_done && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    byte_d     = byte_q;
    last_d     = last_q;
    bit_cnt_d  = bit_cnt_q;
    step_d     = step_q;
    mode_d     = mode_q;
    left_d     = left_q;
    gz_d       = gz_q;
    fv_d       = fv_q;
    loop_d     = loop_q;
    inner_d    = inner_q;
    subflags_d = subflags_q;
    subtot_d   = subtot_q;
    chroma_d   = chroma_q;
    width_d    = width_q;
    height_d   = height_q;
    crop_w_d   = crop_w_q;
    crop_h_d   = crop_h_q;
    poc_d      = poc_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    id_d       = id_q;
    depth_d    = depth_q;
    profile_d  = profile_q;
    level_d    = level_q;
    scale_d    = scale_q;
    units_d    = units_q;
    ovf_d      = ovf_q;
    set_d      = set_q;
    aux_d      = aux_q;
    pend_d     = pend_q;
    deliver    = 1'b0;
    do_fail    = 1'b0;
    dval       = '0;

    if (in_take) begin
      byte_d    = in_req_i.data_byte;
      last_d    = in_req_i.last_byte;
      bit_cnt_d = 4'd8;
    end

    if (ctl_q == C_BITS) begin
      if (mode_q == RM_ISSUE) begin
        case (step_q)
          ST_DONE: mode_d = RM_NONE;
          ST_SUBFLAGS: begin
            if (subtot_q > 4'd1) begin
              mode_d = RM_FIXED;
              left_d = 7'd16;
              fv_d   = '0;
            end else begin
              loop_d = '0;
              step_d = ST_SUBPTL;
            end
          end
          ST_SUBPTL: begin
            if (32'(loop_q) + 32'd1 >= 32'(subtot_q)) begin
              step_d = ST_ID;
            end else begin
              loop_d = loop_q + LCW'(1);
              if (sub_n != '0) begin
                step_d = ST_SUBPTL_SKIP;
                mode_d = RM_FIXED;
                left_d = sub_n;
                fv_d   = '0;
              end
            end
          end
          ST_RPS_BEGIN: begin
            if (loop_q >= LCW'(set_q)) begin
              step_d = ST_LT;
            end else begin
              step_d = (loop_q != '0) ? ST_RPS_PRED : ST_RPS_NEG;
            end
          end
          default: begin
            fv_d = '0;
            if (step_q == ST_LT_ITEM) begin
              mode_d = RM_FIXED;
              left_d = {2'b00, poc_q} + 7'd1;
            end else if (fixed_width(step_q) != '0) begin
              mode_d = RM_FIXED;
              left_d = fixed_width(step_q);
            end else begin
              mode_d = RM_GPRE;
              gz_d   = '0;
            end
          end
        endcase
      end else if (bit_cnt_q != '0) begin
        byte_d    = {byte_q[6:0], 1'b0};
        bit_cnt_d = bit_cnt_q - 4'd1;
        case (mode_q)
          RM_FIXED: begin
            fv_d   = fv_shift;
            left_d = left_q - 7'd1;
            if (left_q == 7'd1) begin
              deliver = 1'b1;
              dval    = fv_shift;
            end
          end
          RM_GPRE: begin
            if (!bit_in) begin
              gz_d = gz_q + 6'd1;
              if (gz_q == 6'd31) begin
                do_fail = 1'b1;
              end
            end else if (gz_q == '0) begin
              deliver = 1'b1;
            end else begin
              mode_d = RM_GSUF;
              left_d = {1'b0, gz_q};
              fv_d   = '0;
            end
          end
          RM_GSUF: begin
            fv_d   = fv_shift;
            left_d = left_q - 7'd1;
            if (left_q == 7'd1) begin
              deliver = 1'b1;
              dval    = gsuf_val;
            end
          end
          default: ;
        endcase
      end
    end

    if (deliver) begin
      mode_d = RM_ISSUE;
      case (step_q)
        ST_HEAD: begin
          if (head_tot > 4'(MAX_SUBLAYERS)) begin
            do_fail = 1'b1;
          end else begin
            subtot_d = head_tot;
            step_d   = ST_PTL_A;
          end
        end
        ST_PTL_A: begin
          profile_d = dval[4:0];
          step_d    = ST_PTL_B;
        end
        ST_PTL_B: step_d = ST_LEVEL;
        ST_LEVEL: begin
          level_d = dval[7:0];
          step_d  = ST_SUBFLAGS;
        end
        ST_SUBFLAGS: begin
          subflags_d = 14'(dval >> sub_sh);
          loop_d     = '0;
          step_d     = ST_SUBPTL;
        end
        ST_SUBPTL_SKIP: step_d = ST_SUBPTL;
        ST_ID: begin
          if (dval > 32'd15) begin
            do_fail = 1'b1;
          end else begin
            id_d   = dval[3:0];
            step_d = ST_CHROMA;
          end
        end
        ST_CHROMA: begin
          if (dval > 32'd3) begin
            do_fail = 1'b1;
          end else begin
            chroma_d = dval[1:0];
            step_d   = (dval == 32'd3) ? ST_SEP : ST_WIDTH;
          end
        end
        ST_SEP: step_d = ST_WIDTH;
        ST_WIDTH: begin
          if (dval > 32'd65535) begin
            do_fail = 1'b1;
          end else begin
            width_d = dval[15:0];
            step_d  = ST_HEIGHT;
          end
        end
        ST_HEIGHT: begin
          if (dval > 32'd65535) begin
            do_fail = 1'b1;
          end else begin
            height_d = dval[15:0];
            step_d   = ST_CONF;
          end
        end
        ST_CONF: begin
          inner_d = '0;
          step_d  = (dval != '0) ? ST_CONF_OFS : ST_LUMA;
        end
        ST_CONF_OFS, ST_DDW_UE: begin
          if (crop_side) begin
            crop_h_d = crop_new;
          end else begin
            crop_w_d = crop_new;
          end
          inner_d = inner_q + ICW'(1);
          if (inner_q + ICW'(1) >= ICW'(4)) begin
            step_d = (step_q == ST_CONF_OFS) ? ST_LUMA : ST_TIMING;
          end
        end
        ST_LUMA: begin
          if (dval > 32'd8) begin
            do_fail = 1'b1;
          end else begin
            depth_d = dval[4:0] + 5'd8;
            step_d  = ST_CDEPTH;
          end
        end
        ST_CDEPTH: step_d = ST_POC;
        ST_POC: begin
          if (dval > 32'd12) begin
            do_fail = 1'b1;
          end else begin
            poc_d  = dval[4:0] + 5'd4;
            step_d = ST_ORDER;
          end
        end
        ST_ORDER: begin
          inner_d = (dval != '0) ? ICW'({subtot_q, 1'b0} + {1'b0, subtot_q}) : ICW'(3);
          step_d  = ST_ORDER_UE;
        end
        ST_ORDER_UE: begin
          inner_d = inner_q - ICW'(1);
          if (inner_q == ICW'(1)) begin
            inner_d = ICW'(6);
            step_d  = ST_SIZES;
          end
        end
        ST_SIZES: begin
          inner_d = inner_q - ICW'(1);
          if (inner_q == ICW'(1)) begin
            step_d = ST_SL_EN;
          end
        end
        ST_SL_EN: step_d = (dval != '0) ? ST_SL_PRESENT : ST_AMP;
        ST_SL_PRESENT: begin
          loop_d  = '0;
          inner_d = '0;
          step_d  = (dval != '0) ? ST_SL_PRED : ST_AMP;
        end
        ST_SL_PRED: begin
          if (dval == '0) begin
            step_d = ST_SL_DELTA;
          end else begin
            aux_d  = ((loop_q == '0) ? 7'd16 : 7'd64) + ((loop_q > LCW'(1)) ? 7'd1 : 7'd0);
            step_d = ST_SL_COEF;
          end
        end
        ST_SL_DELTA, ST_SL_COEF: begin
          if (step_q == ST_SL_COEF) begin
            aux_d = aux_q - 7'd1;
          end
          if (step_q == ST_SL_DELTA || aux_q == 7'd1) begin
            inner_d = sl_wrap ? '0 : sl_inner;
            loop_d  = sl_loop;
            step_d  = (sl_loop >= LCW'(4)) ? ST_AMP : ST_SL_PRED;
          end
        end
        ST_AMP: step_d = ST_PCM;
        ST_PCM: step_d = (dval != '0) ? ST_PCM_BITS : ST_NRPS;
        ST_PCM_BITS: begin
          inner_d = ICW'(2);
          step_d  = ST_PCM_UE;
        end
        ST_PCM_UE: begin
          inner_d = inner_q - ICW'(1);
          if (inner_q == ICW'(1)) begin
            step_d = ST_PCM_LF;
          end
        end
        ST_PCM_LF: step_d = ST_NRPS;
        ST_NRPS: begin
          if (dval > 32'(MAX_RPS_SETS)) begin
            do_fail = 1'b1;
          end else begin
            set_d  = SETW'(dval);
            loop_d = '0;
            prev_d = '0;
            step_d = ST_RPS_BEGIN;
          end
        end
        ST_RPS_PRED: step_d = (dval != '0) ? ST_RPS_SIGN : ST_RPS_NEG;
        ST_RPS_SIGN: step_d = ST_RPS_ABS;
        ST_RPS_ABS: begin
          inner_d = '0;
          cur_d   = '0;
          step_d  = ST_RPS_USED;
        end
        ST_RPS_USED, ST_RPS_USEDELTA: begin
          if (rps_pic) begin
            cur_d = rps_c;
            if (32'(rps_c) > 32'(MAX_RPS_PICS)) begin
              do_fail = 1'b1;
            end else begin
              inner_d = inner_q + ICW'(1);
              if (32'(inner_q) + 32'd1 > 32'(prev_q)) begin
                prev_d = rps_c;
                loop_d = loop_q + LCW'(1);
                step_d = ST_RPS_BEGIN;
              end else begin
                step_d = ST_RPS_USED;
              end
            end
          end else begin
            step_d = ST_RPS_USEDELTA;
          end
        end
        ST_RPS_NEG: begin
          if (dval > 32'(MAX_RPS_PICS)) begin
            do_fail = 1'b1;
          end else begin
            aux_d  = dval[6:0];
            step_d = ST_RPS_POS;
          end
        end
        ST_RPS_POS: begin
          if (dval > 32'(MAX_RPS_PICS) - 32'(aux_q)) begin
            do_fail = 1'b1;
          end else begin
            cur_d   = PICW'(pos_sum);
            inner_d = ICW'(pos_sum);
            if (pos_sum == '0) begin
              prev_d = '0;
              loop_d = loop_q + LCW'(1);
              step_d = ST_RPS_BEGIN;
            end else begin
              step_d = ST_RPS_DELTA;
            end
          end
        end
        ST_RPS_DELTA: step_d = ST_RPS_USEDFLAG;
        ST_RPS_USEDFLAG: begin
          inner_d = inner_q - ICW'(1);
          if (inner_q == ICW'(1)) begin
            prev_d = cur_q;
            loop_d = loop_q + LCW'(1);
            step_d = ST_RPS_BEGIN;
          end else begin
            step_d = ST_RPS_DELTA;
          end
        end
        ST_LT: step_d = (dval != '0) ? ST_LT_NUM : ST_TMVP;
        ST_LT_NUM: begin
          if (dval > 32'd32) begin
            do_fail = 1'b1;
          end else begin
            inner_d = ICW'(dval);
            step_d  = (dval != '0) ? ST_LT_ITEM : ST_TMVP;
          end
        end
        ST_LT_ITEM: begin
          inner_d = inner_q - ICW'(1);
          if (inner_q == ICW'(1)) begin
            step_d = ST_TMVP;
          end
        end
        ST_TMVP: step_d = ST_VUI;
        ST_VUI: step_d = (dval != '0) ? ST_SAR : ST_DONE;
        ST_SAR: step_d = (dval != '0) ? ST_SAR_IDC : ST_OVERSCAN;
        ST_SAR_IDC: step_d = (dval == 32'd255) ? ST_SAR_VAL : ST_OVERSCAN;
        ST_SAR_VAL: step_d = ST_OVERSCAN;
        ST_OVERSCAN: step_d = (dval != '0) ? ST_OVS_APP : ST_VST;
        ST_OVS_APP: step_d = ST_VST;
        ST_VST: step_d = (dval != '0) ? ST_VST_BITS : ST_CLOC;
        ST_VST_BITS: step_d = dval[0] ? ST_COLOUR_BITS : ST_CLOC;
        ST_COLOUR_BITS: step_d = ST_CLOC;
        ST_CLOC: begin
          inner_d = ICW'(2);
          step_d  = (dval != '0) ? ST_CLOC_UE : ST_THREE;
        end
        ST_CLOC_UE: begin
          inner_d = inner_q - ICW'(1);
          if (inner_q == ICW'(1)) begin
            step_d = ST_THREE;
          end
        end
        ST_THREE: step_d = ST_DDW;
        ST_DDW: begin
          if (dval != '0) begin
            inner_d  = '0;
            crop_w_d = '0;
            crop_h_d = '0;
            step_d   = ST_DDW_UE;
          end else begin
            step_d = ST_TIMING;
          end
        end
        ST_TIMING: step_d = (dval != '0) ? ST_T_UNITS : ST_DONE;
        ST_T_UNITS: begin
          units_d = dval;
          step_d  = ST_T_SCALE;
        end
        ST_T_SCALE: begin
          scale_d = dval;
          step_d  = ST_DONE;
        end
        default: step_d = ST_DONE;
      endcase
    end

    if (do_fail) begin
      ovf_d  = 1'b1;
      step_d = ST_DONE;
      mode_d = RM_NONE;
    end

    // The last byte closes the set: capture the result and restart the walker.
    if (rate_start) begin
      pend_d.param_set_id = id_q;
      pend_d.pic_width    = ({2'b00, width_q} > crop_w_q) ? 16'({2'b00, width_q} - crop_w_q) : '0;
      pend_d.pic_height   = ({2'b00, height_q} > crop_h_q) ? 16'({2'b00, height_q} - crop_h_q) : '0;
      pend_d.luma_depth   = depth_q;
      pend_d.profile_code = profile_q;
      pend_d.level_code   = level_q;
      pend_d.rps_count    = 7'(set_q);
      pend_d.rate_num     = '0;
      pend_d.rate_den     = '0;
      pend_d.status       = status;
      step_d     = ST_HEAD;
      mode_d     = RM_ISSUE;
      left_d     = '0;
      gz_d       = '0;
      fv_d       = '0;
      loop_d     = '0;
      inner_d    = '0;
      subflags_d = '0;
      subtot_d   = 4'd1;
      chroma_d   = '0;
      width_d    = '0;
      height_d   = '0;
      crop_w_d   = '0;
      crop_h_d   = '0;
      poc_d      = 5'd4;
      prev_d     = '0;
      cur_d      = '0;
      id_d       = '0;
      depth_d    = '0;
      profile_d  = '0;
      level_d    = '0;
      scale_d    = '0;
      units_d    = '0;
      ovf_d      = 1'b0;
      set_d      = '0;
      aux_d      = '0;
    end
  end

  hsps_rate_unit u_rate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rate_start),
    .scale_i (rate_a),
    .units_i (rate_b),
    .done_o  (rate_done),
    .num_o   (rate_num),
    .den_o   (rate_den)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= C_WAIT;
      bit_cnt_q   <= '0;
      last_q      <= 1'b0;
      step_q      <= ST_HEAD;
      mode_q      <= RM_ISSUE;
      left_q      <= '0;
      gz_q        <= '0;
      fv_q        <= '0;
      loop_q      <= '0;
      inner_q     <= '0;
      subflags_q  <= '0;
      subtot_q    <= 4'd1;
      chroma_q    <= '0;
      width_q     <= '0;
      height_q    <= '0;
      crop_w_q    <= '0;
      crop_h_q    <= '0;
      poc_q       <= 5'd4;
      prev_q      <= '0;
      cur_q       <= '0;
      id_q        <= '0;
      depth_q     <= '0;
      profile_q   <= '0;
      level_q     <= '0;
      scale_q     <= '0;
      units_q     <= '0;
      ovf_q       <= 1'b0;
      set_q       <= '0;
      aux_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ctl_q       <= ctl_d;
      bit_cnt_q   <= bit_cnt_d;
      last_q      <= last_d;
      step_q      <= step_d;
      mode_q      <= mode_d;
      left_q      <= left_d;
      gz_q        <= gz_d;
      fv_q        <= fv_d;
      loop_q      <= loop_d;
      inner_q     <= inner_d;
      subflags_q  <= subflags_d;
      subtot_q    <= subtot_d;
      chroma_q    <= chroma_d;
      width_q     <= width_d;
      height_q    <= height_d;
      crop_w_q    <= crop_w_d;
      crop_h_q    <= crop_h_d;
      poc_q       <= poc_d;
      prev_q      <= prev_d;
      cur_q       <= cur_d;
      id_q        <= id_d;
      depth_q     <= depth_d;
      profile_q   <= profile_d;
      level_q     <= level_d;
      scale_q     <= scale_d;
      units_q     <= units_d;
      ovf_q       <= ovf_d;
      set_q       <= set_d;
      aux_q       <= aux_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    pend_q <= pend_d;
    if (out_load) begin
      out_q          <= pend_q;
      out_q.rate_num <= rate_num;
      out_q.rate_den <= rate_den;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_fail_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> step_q == ST_DONE)
    else $error("range error seen while the walker is still active");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> rate_done)
    else $error("result loaded before the rate reduction finished");

  a_suffix_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == RM_GSUF |-> left_q != '0 && gz_q != '0)
    else $error("exp-Golomb suffix read with no bits left");

  a_take_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ctl_q == C_BITS && bit_cnt_q == 4'd8)
    else $error("accepted byte did not start the bit walk");

  a_rps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_RPS_USED || step_q == ST_RPS_USEDELTA) |->
      32'(cur_q) <= 32'(MAX_RPS_PICS))
    else $error("picture count of a reference set exceeds its bound");

endmodule

`default_nettype wire

FILE: bench/tb_hevc_sps_header_parser.sv
// ----------------------------------------------------------------------------
// Testbench for the HEVC SPS header parser
// Feeds hand-picked byte rows, some with hand-given results, then randomly
// built parameter sets (whole, truncated and pure noise) through the request
// handshake; a bit-serial syntax walker predicts the rest; all are checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hevc_sps_header_parser;
  import hsps_pkg::*;

  localparam int MAX_SETS = 64;
  localparam int MAX_PICS = 32;
  localparam int WDOG_LIMIT = 8000;
  localparam int HOLD_CYCLES = 1500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  hsps_in_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  hsps_out_t out_req_o;

  hevc_sps_header_parser DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_req_o(out_req_o)
  );

  always #10 clk_i = ~clk_i;

  hsps_out_t sps_expected_q[$];
  int mismatches = 0;
  int sps_checked = 0;
  bit calm = 1'b0;
  int wdog = 0;

  // Syntax walker state.
  step_e ps;
  rmode_e rm;
  logic [7:0] rleft, lcnt, icnt, nsets, aux, prevp, curp;
  logic [5:0] gz;
  logic [31:0] fv;
  logic [13:0] sflags;
  logic [3:0] stot;
  logic [1:0] cfmt;
  logic [15:0] csz[2];
  logic [17:0] crop[2];
  logic [4:0] pbits;
  logic [7:0] sps_id, depth, prof, lvl;
  logic [31:0] tscale, tunits;
  bit range_err;

  function automatic int field_width(step_e s);
    case (s)
      ST_HEAD, ST_PTL_A, ST_LEVEL, ST_PCM_BITS, ST_SAR_IDC: return 8;
      ST_PTL_B: return 80;
      ST_AMP, ST_TMVP: return 2;
      ST_SAR_VAL, ST_T_UNITS, ST_T_SCALE: return 32;
      ST_VST_BITS: return 5;
      ST_COLOUR_BITS: return 24;
      ST_THREE: return 3;
      ST_SEP, ST_CONF, ST_ORDER, ST_SL_EN, ST_SL_PRESENT, ST_SL_PRED, ST_PCM,
      ST_PCM_LF, ST_RPS_PRED, ST_RPS_SIGN, ST_RPS_USED, ST_RPS_USEDELTA,
      ST_RPS_USEDFLAG, ST_LT, ST_VUI, ST_SAR, ST_OVERSCAN, ST_OVS_APP, ST_VST,
      ST_CLOC, ST_DDW, ST_TIMING: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic void walk_abort();
    range_err = 1'b1;
    ps = ST_DONE;
    rm = RM_NONE;
  endfunction

  function automatic void next_field();
    int fb, n;
    while (1) begin
      if (ps == ST_DONE) begin
        rm = RM_NONE;
        return;
      end
      if (ps == ST_SUBFLAGS) begin
        if (stot > 1) begin
          rm = RM_FIXED; rleft = 16; fv = 0;
          return;
        end
        lcnt = 0; ps = ST_SUBPTL;
        continue;
      end
      if (ps == ST_SUBPTL) begin
        if (int'(lcnt) + 1 >= int'(stot)) begin
          ps = ST_ID;
          continue;
        end
        fb = 2 * (int'(stot) - 1) - 1 - 2 * int'(lcnt);
        n = (sflags[fb] ? 88 : 0) + (sflags[fb-1] ? 8 : 0);
        lcnt++;
        if (n == 0) continue;
        ps = ST_SUBPTL_SKIP; rm = RM_FIXED; rleft = n; fv = 0;
        return;
      end
      if (ps == ST_RPS_BEGIN) begin
        if (lcnt >= nsets) ps = ST_LT;
        else ps = (lcnt != 0) ? ST_RPS_PRED : ST_RPS_NEG;
        continue;
      end
      fv = 0;
      if (ps == ST_LT_ITEM) begin
        rm = RM_FIXED; rleft = pbits + 1;
        return;
      end
      if (field_width(ps) != 0) begin
        rm = RM_FIXED; rleft = field_width(ps);
        return;
      end
      rm = RM_GPRE; gz = 0;
      return;
    end
  endfunction

  function automatic void add_window(logic [31:0] v);
    int side;
    longint unsigned mult, sum;
    side = (icnt < 2) ? 0 : 1;
    mult = 1;
    if (side == 0 && (cfmt == 1 || cfmt == 2)) mult = 2;
    if (side == 1 && cfmt == 1) mult = 2;
    sum = longint'(crop[side]) + longint'(v) * mult;
    crop[side] = (sum > 64'h3FFFF) ? 18'h3FFFF : sum[17:0];
  endfunction

  function automatic void scaling_next();
    icnt = icnt + ((lcnt == 3) ? 8'd3 : 8'd1);
    if (icnt >= 6) begin
      icnt = 0; lcnt++;
    end
    ps = (lcnt >= 4) ? ST_AMP : ST_SL_PRED;
  endfunction

  function automatic void set_end();
    prevp = curp; lcnt++; ps = ST_RPS_BEGIN;
  endfunction

  function automatic void set_next_pic();
    if (curp > MAX_PICS) begin
      walk_abort();
      return;
    end
    icnt++;
    if (icnt > prevp) set_end();
    else ps = ST_RPS_USED;
  endfunction

  function automatic void take_field(logic [31:0] v);
    case (ps)
      ST_HEAD: begin
        stot = v[3:1] + 4'd1;
        ps = ST_PTL_A;
      end
      ST_PTL_A: begin prof = {3'b0, v[4:0]}; ps = ST_PTL_B; end
      ST_PTL_B: ps = ST_LEVEL;
      ST_LEVEL: begin lvl = v[7:0]; ps = ST_SUBFLAGS; end
      ST_SUBFLAGS: begin
        sflags = 14'(v >> (2 * (9 - int'(stot))));
        lcnt = 0; ps = ST_SUBPTL;
      end
      ST_SUBPTL_SKIP: ps = ST_SUBPTL;
      ST_ID: begin
        if (v > 15) begin walk_abort(); return; end
        sps_id = v[7:0]; ps = ST_CHROMA;
      end
      ST_CHROMA: begin
        if (v > 3) begin walk_abort(); return; end
        cfmt = v[1:0]; ps = (v == 3) ? ST_SEP : ST_WIDTH;
      end
      ST_SEP: ps = ST_WIDTH;
      ST_WIDTH: begin
        if (v > 65535) begin walk_abort(); return; end
        csz[0] = v[15:0]; ps = ST_HEIGHT;
      end
      ST_HEIGHT: begin
        if (v > 65535) begin walk_abort(); return; end
        csz[1] = v[15:0]; ps = ST_CONF;
      end
      ST_CONF: begin icnt = 0; ps = (v != 0) ? ST_CONF_OFS : ST_LUMA; end
      ST_CONF_OFS: begin
        add_window(v);
        icnt++;
        if (icnt >= 4) ps = ST_LUMA;
      end
      ST_LUMA: begin
        if (v > 8) begin walk_abort(); return; end
        depth = v[7:0] + 8'd8; ps = ST_CDEPTH;
      end
      ST_CDEPTH: ps = ST_POC;
      ST_POC: begin
        if (v > 12) begin walk_abort(); return; end
        pbits = v[4:0] + 5'd4; ps = ST_ORDER;
      end
      ST_ORDER: begin icnt = 8'd3 * ((v != 0) ? 8'(stot) : 8'd1); ps = ST_ORDER_UE; end
      ST_ORDER_UE: begin
        icnt--;
        if (icnt == 0) begin icnt = 6; ps = ST_SIZES; end
      end
      ST_SIZES: begin icnt--; if (icnt == 0) ps = ST_SL_EN; end
      ST_SL_EN: ps = (v != 0) ? ST_SL_PRESENT : ST_AMP;
      ST_SL_PRESENT: begin
        lcnt = 0; icnt = 0; ps = (v != 0) ? ST_SL_PRED : ST_AMP;
      end
      ST_SL_PRED: begin
        if (v == 0) ps = ST_SL_DELTA;
        else begin
          aux = ((lcnt == 0) ? 8'd16 : 8'd64) + ((lcnt > 1) ? 8'd1 : 8'd0);
          ps = ST_SL_COEF;
        end
      end
      ST_SL_DELTA: scaling_next();
      ST_SL_COEF: begin aux--; if (aux == 0) scaling_next(); end
      ST_AMP: ps = ST_PCM;
      ST_PCM: ps = (v != 0) ? ST_PCM_BITS : ST_NRPS;
      ST_PCM_BITS: begin icnt = 2; ps = ST_PCM_UE; end
      ST_PCM_UE: begin icnt--; if (icnt == 0) ps = ST_PCM_LF; end
      ST_PCM_LF: ps = ST_NRPS;
      ST_NRPS: begin
        if (v > MAX_SETS) begin walk_abort(); return; end
        nsets = v[7:0]; lcnt = 0; prevp = 0; ps = ST_RPS_BEGIN;
      end
      ST_RPS_PRED: ps = (v != 0) ? ST_RPS_SIGN : ST_RPS_NEG;
      ST_RPS_SIGN: ps = ST_RPS_ABS;
      ST_RPS_ABS: begin icnt = 0; curp = 0; ps = ST_RPS_USED; end
      ST_RPS_USED: begin
        if (v != 0) begin curp++; set_next_pic(); end
        else ps = ST_RPS_USEDELTA;
      end
      ST_RPS_USEDELTA: begin
        if (v != 0) curp++;
        set_next_pic();
      end
      ST_RPS_NEG: begin
        if (v > MAX_PICS) begin walk_abort(); return; end
        aux = v[7:0]; ps = ST_RPS_POS;
      end
      ST_RPS_POS: begin
        if (v > 32'(MAX_PICS - int'(aux))) begin walk_abort(); return; end
        curp = aux + v[7:0]; icnt = curp;
        if (icnt == 0) set_end();
        else ps = ST_RPS_DELTA;
      end
      ST_RPS_DELTA: ps = ST_RPS_USEDFLAG;
      ST_RPS_USEDFLAG: begin
        icnt--;
        if (icnt == 0) set_end();
        else ps = ST_RPS_DELTA;
      end
      ST_LT: ps = (v != 0) ? ST_LT_NUM : ST_TMVP;
      ST_LT_NUM: begin
        if (v > 32) begin walk_abort(); return; end
        icnt = v[7:0]; ps = (v != 0) ? ST_LT_ITEM : ST_TMVP;
      end
      ST_LT_ITEM: begin icnt--; if (icnt == 0) ps = ST_TMVP; end
      ST_TMVP: ps = ST_VUI;
      ST_VUI: ps = (v != 0) ? ST_SAR : ST_DONE;
      ST_SAR: ps = (v != 0) ? ST_SAR_IDC : ST_OVERSCAN;
      ST_SAR_IDC: ps = (v == 255) ? ST_SAR_VAL : ST_OVERSCAN;
      ST_SAR_VAL: ps = ST_OVERSCAN;
      ST_OVERSCAN: ps = (v != 0) ? ST_OVS_APP : ST_VST;
      ST_OVS_APP: ps = ST_VST;
      ST_VST: ps = (v != 0) ? ST_VST_BITS : ST_CLOC;
      ST_VST_BITS: ps = v[0] ? ST_COLOUR_BITS : ST_CLOC;
      ST_COLOUR_BITS: ps = ST_CLOC;
      ST_CLOC: begin icnt = 2; ps = (v != 0) ? ST_CLOC_UE : ST_THREE; end
      ST_CLOC_UE: begin icnt--; if (icnt == 0) ps = ST_THREE; end
      ST_THREE: ps = ST_DDW;
      ST_DDW: begin
        if (v != 0) begin
          icnt = 0; crop[0] = 0; crop[1] = 0; ps = ST_DDW_UE;
        end else ps = ST_TIMING;
      end
      ST_DDW_UE: begin
        add_window(v);
        icnt++;
        if (icnt >= 4) ps = ST_TIMING;
      end
      ST_TIMING: ps = (v != 0) ? ST_T_UNITS : ST_DONE;
      ST_T_UNITS: begin tunits = v; ps = ST_T_SCALE; end
      ST_T_SCALE: begin tscale = v; ps = ST_DONE; end
      default: ps = ST_DONE;
    endcase
  endfunction

  function automatic void deliver(logic [31:0] v);
    rm = RM_NONE;
    take_field(v);
    next_field();
  endfunction

  function automatic void walk_bit(bit b);
    case (rm)
      RM_FIXED: begin
        fv = {fv[30:0], b};
        rleft--;
        if (rleft == 0) deliver(fv);
      end
      RM_GPRE: begin
        if (!b) begin
          gz++;
          if (gz > 31) walk_abort();
        end else if (gz == 0) deliver(0);
        else begin
          rm = RM_GSUF; rleft = 8'(gz); fv = 0;
        end
      end
      RM_GSUF: begin
        fv = {fv[30:0], b};
        rleft--;
        if (rleft == 0) deliver(((32'd1 << gz) - 32'd1) + fv);
      end
      default: ;
    endcase
  endfunction

  function automatic void walker_clear();
    gz = 0; fv = 0; lcnt = 0; icnt = 0; sflags = 0; stot = 1; cfmt = 0;
    pbits = 4; csz[0] = 0; csz[1] = 0; crop[0] = 0; crop[1] = 0;
    prevp = 0; curp = 0; sps_id = 0; depth = 0; prof = 0; lvl = 0;
    tscale = 0; tunits = 0; range_err = 1'b0; rm = RM_NONE; rleft = 0;
    nsets = 0; aux = 0; ps = ST_HEAD;
    next_field();
  endfunction

  function automatic bit walk_byte(hsps_in_t it, output hsps_out_t r);
    logic [31:0] a, b, t;
    r = '0;
    for (int i = 7; i >= 0; i--) walk_bit(it.data_byte[i]);
    if (!it.last_byte) return 1'b0;
    r.status = range_err ? STAT_RANGE : ((ps != ST_DONE) ? STAT_SHORT : STAT_OK);
    if (r.status == STAT_OK && (tscale | tunits) != 0) begin
      a = tscale; b = tunits;
      while (b != 0) begin
        t = a % b; a = b; b = t;
      end
      r.rate_num = tscale / a;
      r.rate_den = tunits / a;
    end
    r.param_set_id = sps_id[3:0];
    r.pic_width = (18'(csz[0]) > crop[0]) ? 16'(18'(csz[0]) - crop[0]) : 16'd0;
    r.pic_height = (18'(csz[1]) > crop[1]) ? 16'(18'(csz[1]) - crop[1]) : 16'd0;
    r.luma_depth = depth[4:0];
    r.profile_code = prof[4:0];
    r.level_code = lvl;
    r.rps_count = nsets[6:0];
    walker_clear();
    return 1'b1;
  endfunction

  // Stream builder.
  bit sps_bits[$];
  logic [7:0] sps_bytes[$];
  int bytes_sent = 0;

  function automatic void put(longint unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) sps_bits.push_back(v[i]);
  endfunction

  function automatic void put_ue(longint unsigned v);
    longint unsigned w;
    int n;
    w = v + 1;
    n = 0;
    while ((w >> n) != 0) n++;
    put(0, n - 1);
    put(w, n);
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic void build_sps();
    int sl, pocb, cnt, prevn, curn, neg, pos, k;
    bit pf[8], lf[8], used;
    logic [31:0] u, s;
    sps_bits.delete();
    sl = chance(30) ? $urandom_range(0, 7) : $urandom_range(0, 1);
    put(($urandom_range(0, 15) << 4) | (sl << 1) | $urandom_range(0, 1), 8);
    repeat (12) put($urandom_range(0, 255), 8);
    if (sl > 0) begin
      for (int i = 0; i < 8; i++) begin
        pf[i] = (i < sl) ? $urandom_range(0, 1) : 0;
        lf[i] = (i < sl) ? $urandom_range(0, 1) : 0;
        put(pf[i], 1);
        put(lf[i], 1);
      end
      for (int i = 0; i < sl; i++) begin
        if (pf[i]) repeat (11) put($urandom_range(0, 255), 8);
        if (lf[i]) put($urandom_range(0, 255), 8);
      end
    end
    put_ue(chance(4) ? $urandom_range(16, 40) : $urandom_range(0, 15));
    k = chance(4) ? $urandom_range(4, 9) : $urandom_range(0, 3);
    put_ue(k);
    if (k == 3) put($urandom_range(0, 1), 1);
    repeat (2) begin
      if (chance(3)) put_ue(65536);
      else if (chance(8)) put_ue(chance(50) ? 65535 : $urandom_range(0, 65535));
      else put_ue($urandom_range(8, 4096));
    end
    if (chance(50)) begin
      put(1, 1);
      repeat (4) put_ue(chance(10) ? $urandom_range(40000, 300000) : $urandom_range(0, 64));
    end else put(0, 1);
    put_ue(chance(4) ? 9 : $urandom_range(0, 8));
    put_ue($urandom_range(0, 8));
    pocb = chance(4) ? 13 : $urandom_range(0, 12);
    put_ue(pocb);
    pocb = pocb + 4;
    k = $urandom_range(0, 1);
    put(k, 1);
    repeat (3 * (k ? sl + 1 : 1)) put_ue($urandom_range(0, 10));
    repeat (6) put_ue($urandom_range(0, 5));
    if (chance(15)) begin
      put(1, 1);
      if (chance(60)) begin
        put(1, 1);
        for (int sz = 0; sz < 4; sz++)
          for (int m = 0; m < 6; m += (sz == 3) ? 3 : 1) begin
            if (chance(30)) begin
              put(1, 1);
              repeat (((sz == 0) ? 16 : 64) + (sz > 1)) put_ue($urandom_range(0, 2));
            end else begin
              put(0, 1);
              put_ue($urandom_range(0, 3));
            end
          end
      end else put(0, 1);
    end else put(0, 1);
    put($urandom_range(0, 3), 2);
    if (chance(30)) begin
      put(1, 1); put($urandom_range(0, 255), 8);
      put_ue($urandom_range(0, 3)); put_ue($urandom_range(0, 3)); put($urandom_range(0, 1), 1);
    end else put(0, 1);
    cnt = chance(3) ? 65 : (chance(8) ? $urandom_range(5, 64) : $urandom_range(0, 4));
    put_ue(cnt);
    prevn = 0;
    for (int st = 0; st < cnt && st < MAX_SETS; st++) begin
      if (st > 0 && chance(50)) begin
        put(1, 1); put($urandom_range(0, 1), 1); put_ue($urandom_range(0, 5));
        curn = 0;
        for (int j = 0; j <= prevn; j++) begin
          used = $urandom_range(0, 1);
          put(used, 1);
          if (used) curn++;
          else begin
            used = $urandom_range(0, 1);
            put(used, 1);
            if (used) curn++;
          end
        end
      end else begin
        if (st > 0) put(0, 1);
        if (chance(5)) begin
          neg = chance(30) ? 33 : $urandom_range(10, 32);
          pos = (neg > MAX_PICS) ? 0 : MAX_PICS - neg + (chance(30) ? 1 : 0);
        end else begin
          neg = $urandom_range(0, 3);
          pos = $urandom_range(0, 3);
        end
        put_ue(neg);
        put_ue(pos);
        curn = neg + pos;
        repeat (curn) begin
          put_ue($urandom_range(0, 7));
          put($urandom_range(0, 1), 1);
        end
      end
      prevn = curn;
    end
    if (chance(40)) begin
      put(1, 1);
      k = chance(5) ? (chance(50) ? 33 : 32) : $urandom_range(0, 3);
      put_ue(k);
      repeat (k) put($urandom, pocb + 1);
    end else put(0, 1);
    put($urandom_range(0, 3), 2);
    if (chance(75)) begin
      put(1, 1);
      if (chance(50)) begin
        put(1, 1);
        k = chance(50) ? 255 : $urandom_range(0, 254);
        put(k, 8);
        if (k == 255) put($urandom, 32);
      end else put(0, 1);
      if (chance(50)) begin put(1, 1); put($urandom_range(0, 1), 1); end
      else put(0, 1);
      if (chance(50)) begin
        put(1, 1);
        k = $urandom_range(0, 31);
        put(k, 5);
        if (k[0]) put($urandom, 24);
      end else put(0, 1);
      if (chance(50)) begin
        put(1, 1); put_ue($urandom_range(0, 5)); put_ue($urandom_range(0, 5));
      end else put(0, 1);
      put($urandom_range(0, 7), 3);
      if (chance(40)) begin
        put(1, 1);
        repeat (4) put_ue(chance(10) ? $urandom_range(40000, 300000) : $urandom_range(0, 64));
      end else put(0, 1);
      if (chance(80)) begin
        put(1, 1);
        case ($urandom_range(0, 4))
          0: begin u = $urandom; s = $urandom; end
          1: begin
            k = $urandom_range(1, 1000);
            u = k * $urandom_range(1, 1001);
            s = k * $urandom_range(1, 60000);
          end
          2: begin u = $urandom; s = 0; end
          3: begin u = 0; s = $urandom; end
          default: begin u = 0; s = 0; end
        endcase
        put(u, 32);
        put(s, 32);
      end else put(0, 1);
    end else put(0, 1);
    while (sps_bits.size() % 8 != 0) put($urandom_range(0, 1), 1);
    if (chance(25)) repeat ($urandom_range(1, 2)) put($urandom_range(0, 255), 8);
  endfunction

  function automatic void make_bytes();
    int n;
    sps_bytes.delete();
    for (int i = 0; i < sps_bits.size(); i += 8) begin
      logic [7:0] b;
      for (int j = 0; j < 8; j++) b[7-j] = sps_bits[i+j];
      sps_bytes.push_back(b);
    end
    if (chance(10)) begin
      n = $urandom_range(1, sps_bytes.size());
      while (sps_bytes.size() > n) void'(sps_bytes.pop_back());
    end
  endfunction

  task automatic send_byte(logic [7:0] b, bit last, bit typed, hsps_out_t tres);
    hsps_in_t it;
    hsps_out_t r;
    if (!calm && chance(21)) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    it.data_byte = b;
    it.last_byte = last;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (walk_byte(it, r)) sps_expected_q.push_back(typed ? tres : r);
  endtask

  typedef struct {
    logic [7:0] b;
    bit last;
    bit typed;
    hsps_out_t res;
  } row_t;

  initial begin
    row_t rows[$];
    hsps_out_t short_res, range_res, none;
    int nsps;
    short_res = '0;
    short_res.status = STAT_SHORT;
    range_res = '0;
    range_res.status = STAT_RANGE;
    none = '0;
    walker_clear();
    rows.push_back('{8'h00, 1'b1, 1'b1, short_res});
    rows.push_back('{8'hFF, 1'b1, 1'b1, short_res});
    // Thirty-two zero bits in the id code overrun the prefix limit.
    for (int i = 0; i < 17; i++) rows.push_back('{8'h00, i == 16, i == 16, range_res});
    rows.push_back('{8'hA5, 1'b0, 1'b0, none});
    rows.push_back('{8'h5A, 1'b1, 1'b0, none});
    rows.push_back('{8'h7F, 1'b0, 1'b0, none});
    rows.push_back('{8'h01, 1'b1, 1'b0, none});

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_byte(rows[i].b, rows[i].last, rows[i].typed, rows[i].res);

    nsps = 0;
    while (bytes_sent < 1100 || nsps < 60) begin
      calm = (bytes_sent > 400 && bytes_sent < 650);
      if (chance(20)) begin
        sps_bytes.delete();
        repeat ($urandom_range(1, 8)) sps_bytes.push_back($urandom_range(0, 255));
      end else begin
        build_sps();
        make_bytes();
      end
      foreach (sps_bytes[i]) send_byte(sps_bytes[i], i == sps_bytes.size() - 1, 1'b0, none);
      nsps++;
    end
    calm = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sps_expected_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Result side stalls; one long hold-off lets the parser back up.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && sps_checked >= 12) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i <= !calm && chance(21);
    end
  end

  always @(posedge clk_i) begin
    hsps_out_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sps_checked++;
      if (sps_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_req_o);
      end else begin
        exp_res = sps_expected_q.pop_front();
        if (out_req_o.param_set_id !== exp_res.param_set_id ||
            out_req_o.pic_width !== exp_res.pic_width ||
            out_req_o.pic_height !== exp_res.pic_height ||
            out_req_o.luma_depth !== exp_res.luma_depth ||
            out_req_o.profile_code !== exp_res.profile_code ||
            out_req_o.level_code !== exp_res.level_code ||
            out_req_o.rps_count !== exp_res.rps_count ||
            out_req_o.rate_num !== exp_res.rate_num ||
            out_req_o.rate_den !== exp_res.rate_den ||
            out_req_o.status !== exp_res.status) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_res, out_req_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog > WDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
